// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/kasq_pkg.sv =====
// ----------------------------------------------------------------------------
// Key and scratch qualifier package
// Field widths, register reset values, action and register codes, and the
// control structures passed between the slot cells and the scratch unit.
// ----------------------------------------------------------------------------
package kasq_pkg;

  // Payload field widths
  localparam int ACTION_BITS = 3;
  localparam int KEY_BITS    = 8;
  localparam int AXIS_BITS   = 16;
  localparam int SLOT_BITS   = 4;
  localparam int MASK_BITS   = 9;
  localparam int TOTAL_BITS  = 28;
  localparam int OUT_COUNT_BITS = 24;
  localparam int OUT_SLOTS   = 9;

  // Widest binding code that a slot may hold; comparisons run at this width.
  localparam int CMP_BITS = 16;

  // Scratch accumulator widths and limits
  localparam int SUM_BITS    = 24;
  localparam int FRAME_BITS  = 7;
  localparam int SCRATCH_SLOT = 7;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int THRESH_BITS    = 16;
  localparam int WINDOW_BITS    = 6;
  localparam int HALF_BITS      = 16;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd3000;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 6'd4;
  localparam logic [HALF_BITS-1:0]   HALF_RESET   = 16'd32768;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_WRAP_HALF = 2'd2,
    CFG_ENABLE    = 2'd3
  } kasq_cfg_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_KEY_DOWN = 3'd0,
    ACT_KEY_UP   = 3'd1,
    ACT_TICK     = 3'd2,
    ACT_BIND     = 3'd3,
    ACT_CLEAR    = 3'd4
  } kasq_action_t;

  // Command broadcast to every slot cell for one accepted item
  typedef struct packed {
    logic                go;
    kasq_action_t        action;
    logic [KEY_BITS-1:0] code;
  } kasq_cmd_t;

  // Scratch decision for the scratch slot
  typedef struct packed {
    logic fire;
    logic release_slot;
  } kasq_scratch_t;

endpackage

// ===== design/kasq_if.sv =====
// ----------------------------------------------------------------------------
// Key and scratch qualifier channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kasq_item_if;
  logic                                  valid;
  logic                                  ready;
  logic        [kasq_pkg::ACTION_BITS-1:0] action;
  logic        [kasq_pkg::KEY_BITS-1:0]    key_code;
  logic signed [kasq_pkg::AXIS_BITS-1:0]   axis_value;
  logic        [kasq_pkg::SLOT_BITS-1:0]   bind_slot;

  modport source (output valid, action, key_code, axis_value, bind_slot, input ready);
  modport sink   (input valid, action, key_code, axis_value, bind_slot, output ready);
endinterface

interface kasq_result_if;
  logic                                    valid;
  logic                                    ready;
  logic [kasq_pkg::MASK_BITS-1:0]          pressed_mask;
  logic                                    scratch_fired;
  logic [kasq_pkg::TOTAL_BITS-1:0]         total_count;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_one;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_two;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_three;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_four;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_five;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_six;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_key_seven;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_scratch_left;
  logic [kasq_pkg::OUT_COUNT_BITS-1:0]     count_scratch_right;

  modport source (output valid, pressed_mask, scratch_fired, total_count, count_key_one,
                  count_key_two, count_key_three, count_key_four, count_key_five,
                  count_key_six, count_key_seven, count_scratch_left,
                  count_scratch_right, input ready);
  modport sink   (input valid, pressed_mask, scratch_fired, total_count, count_key_one,
                  count_key_two, count_key_three, count_key_four, count_key_five,
                  count_key_six, count_key_seven, count_scratch_left,
                  count_scratch_right, output ready);
endinterface

// ===== design/kasq_slot_cell.sv =====
// ----------------------------------------------------------------------------
// Key slot cell
// Holds one slot's binding, pressed flag and saturating press count, and
// passes the running count of presses in this transfer on to its neighbour.
// ----------------------------------------------------------------------------
module kasq_slot_cell #(
  parameter int COUNT_BITS = 24,
  parameter int CODE_BITS  = 8,
  parameter int BUMP_BITS  = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  kasq_pkg::kasq_cmd_t      cmd,
  input  logic                     bind_sel,
  input  kasq_pkg::kasq_scratch_t  scratch,
  input  logic [BUMP_BITS-1:0]     bump_in,
  output logic [BUMP_BITS-1:0]     bump_out,
  output logic                     pressed_next,
  output logic [COUNT_BITS-1:0]    count_next
);

  logic [CODE_BITS-1:0]  binding;
  logic [CODE_BITS-1:0]  binding_next;
  logic                  pressed;
  logic [COUNT_BITS-1:0] count;
  logic [kasq_pkg::CMP_BITS-1:0] code_wide;
  logic [kasq_pkg::CMP_BITS-1:0] binding_wide;
  logic                  match;
  logic                  press;
  logic                  bumped;

  // Compare the incoming code with the binding at a common width.
  assign code_wide    = kasq_pkg::CMP_BITS'(cmd.code);
  assign binding_wide = kasq_pkg::CMP_BITS'(binding);
  assign match        = (code_wide == binding_wide);

  // Decide the slot's next state for this transfer.
  always_comb begin
    binding_next = binding;
    pressed_next = pressed;
    count_next   = count;
    press        = 1'b0;
    if (cmd.go) begin
      case (cmd.action)
        kasq_pkg::ACT_KEY_DOWN: begin
          if (match && !pressed) begin
            press = 1'b1;
          end
        end
        kasq_pkg::ACT_KEY_UP: begin
          if (match) begin
            pressed_next = 1'b0;
          end
        end
        kasq_pkg::ACT_TICK: begin
          if (scratch.fire) begin
            press = 1'b1;
          end else if (scratch.release_slot) begin
            pressed_next = 1'b0;
          end
        end
        kasq_pkg::ACT_BIND: begin
          if (bind_sel) begin
            binding_next = code_wide[CODE_BITS-1:0];
          end
        end
        kasq_pkg::ACT_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
    bumped = press && (count != {COUNT_BITS{1'b1}});
    if (press) begin
      pressed_next = 1'b1;
    end
    if (bumped) begin
      count_next = count + COUNT_BITS'(1);
    end
  end

  // Running tally of counted presses along the row.
  assign bump_out = bump_in + BUMP_BITS'(bumped);

  always_ff @(posedge clk) begin
    if (rst) begin
      binding <= '0;
      pressed <= 1'b0;
      count   <= '0;
    end else begin
      binding <= binding_next;
      pressed <= pressed_next;
      count   <= count_next;
    end
  end

endmodule

// ===== design/kasq_scratch.sv =====
// ----------------------------------------------------------------------------
// Scratch detector
// Accumulates wrapped turntable motion over frame ticks and decides whether
// the scratch slot fires or releases within the frame window.
// ----------------------------------------------------------------------------
module kasq_scratch (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   tick,
  input  logic signed [kasq_pkg::AXIS_BITS-1:0]  axis_value,
  input  logic [kasq_pkg::THRESH_BITS-1:0]       scratch_threshold,
  input  logic [kasq_pkg::WINDOW_BITS-1:0]       frame_window,
  input  logic [kasq_pkg::HALF_BITS-1:0]         wrap_half,
  input  logic                                   slot_pressed,
  output kasq_pkg::kasq_scratch_t                scratch
);

  localparam int DW = kasq_pkg::AXIS_BITS + 3;
  localparam int SW = kasq_pkg::SUM_BITS;
  localparam int FW = kasq_pkg::FRAME_BITS;

  logic        [SW-1:0]                  motion_sum;
  logic        [FW-1:0]                  frames_seen;
  logic signed [kasq_pkg::AXIS_BITS-1:0] last_axis;

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] half_s;
  logic signed [DW-1:0] wrapped;
  logic        [DW-1:0] mag;
  logic        [SW:0]   sum_wide;
  logic        [SW-1:0] sum_sat;
  logic        [FW-1:0] frames_inc;
  logic                 fire;
  logic                 release_slot;

  // Axis change, wrapped into one span around zero.
  always_comb begin
    diff   = DW'(axis_value) - DW'(last_axis);
    half_s = DW'(wrap_half);
    if (diff > (half_s - DW'(1))) begin
      wrapped = diff - (half_s <<< 1);
    end else if (diff < -half_s) begin
      wrapped = diff + (half_s <<< 1);
    end else begin
      wrapped = diff;
    end
    mag = (wrapped < 0) ? DW'(-wrapped) : DW'(wrapped);
  end

  // Saturating motion sum and frame count.
  assign sum_wide   = (SW + 1)'(motion_sum) + (SW + 1)'(mag);
  assign sum_sat    = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
  assign frames_inc = (frames_seen == {FW{1'b1}}) ? frames_seen : frames_seen + FW'(1);

  // Fire when the threshold is reached inside the window and the slot is not held; release past it.
  assign fire = (sum_sat >= SW'(scratch_threshold)) &&
                (frames_inc <= FW'(frame_window)) && !slot_pressed;
  assign release_slot = !fire && (frames_inc > FW'(frame_window));

  assign scratch.fire         = tick && fire;
  assign scratch.release_slot = tick && release_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_sum  <= '0;
      frames_seen <= '0;
      last_axis   <= '0;
    end else if (tick) begin
      last_axis <= axis_value;
      if (fire || release_slot) begin
        motion_sum  <= '0;
        frames_seen <= '0;
      end else begin
        motion_sum  <= sum_sat;
        frames_seen <= frames_inc;
      end
    end
  end

endmodule

// ===== design/key_and_scratch_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// Key and scratch qualifier core
// A result is offered in the cycle after its item is transferred.
// Throughput: one item per cycle unless the result receiver stalls; the row
// of slot cells and the scratch accumulator settle each item as it transfers.
// Reset clears bindings, pressed flags, counts, the scratch accumulator and
// the result valid flag, and loads the configuration register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_and_scratch_qualifier_core #(
  parameter int NUM_SLOTS  = 9,
  parameter int COUNT_BITS = 24,
  parameter int CODE_BITS  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [kasq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [kasq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  kasq_item_if.sink                            item,
  kasq_result_if.source                        result
);

  localparam int BUMP_BITS = $clog2(NUM_SLOTS + 1);
  localparam int OUTS      = kasq_pkg::OUT_SLOTS;
  localparam int OCB       = kasq_pkg::OUT_COUNT_BITS;

  // Configuration registers
  logic [kasq_pkg::THRESH_BITS-1:0] scratch_threshold;
  logic [kasq_pkg::WINDOW_BITS-1:0] frame_window;
  logic [kasq_pkg::HALF_BITS-1:0]   wrap_half;
  logic                             scratch_enable;

  logic                    go;
  kasq_pkg::kasq_cmd_t     cmd;
  kasq_pkg::kasq_scratch_t scratch;
  logic                    tick;
  logic                    scratch_slot_q;

  logic [BUMP_BITS-1:0]    bump_chain [NUM_SLOTS+1];
  logic                    pressed_next [NUM_SLOTS];
  logic [COUNT_BITS-1:0]   count_next [NUM_SLOTS];
  logic [OUTS-1:0]         mask_next;
  logic [OCB-1:0]          out_count_next [OUTS];

  logic [kasq_pkg::TOTAL_BITS-1:0] total;
  logic [kasq_pkg::TOTAL_BITS-1:0] total_next;

  // Output register
  logic                            out_valid;
  logic [kasq_pkg::MASK_BITS-1:0]  out_mask;
  logic                            out_fired;
  logic [kasq_pkg::TOTAL_BITS-1:0] out_total;
  logic [OCB-1:0]                  out_count [OUTS];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scratch_threshold <= kasq_pkg::THRESH_RESET;
      frame_window      <= kasq_pkg::WINDOW_RESET;
      wrap_half         <= kasq_pkg::HALF_RESET;
      scratch_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (kasq_pkg::kasq_cfg_t'(cfg_index))
        kasq_pkg::CFG_THRESHOLD: scratch_threshold <= cfg_data[kasq_pkg::THRESH_BITS-1:0];
        kasq_pkg::CFG_WINDOW:    frame_window      <= cfg_data[kasq_pkg::WINDOW_BITS-1:0];
        kasq_pkg::CFG_WRAP_HALF: wrap_half         <= cfg_data[kasq_pkg::HALF_BITS-1:0];
        kasq_pkg::CFG_ENABLE:    scratch_enable    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Transfer control: the output register frees itself when it is taken.
  assign item.ready = !out_valid || result.ready;
  assign go         = item.valid && item.ready;

  assign cmd.go     = go;
  assign cmd.action = kasq_pkg::kasq_action_t'(item.action);
  assign cmd.code   = item.key_code;

  assign tick = go && (cmd.action == kasq_pkg::ACT_TICK) && scratch_enable;

  // Registered pressed flag of the scratch slot, kept alongside the cell.
  // Without a scratch slot the detector sees it as held, so it never fires.
  generate
    if (kasq_pkg::SCRATCH_SLOT < NUM_SLOTS) begin : g_has_scratch
      always_ff @(posedge clk) begin
        if (rst) begin
          scratch_slot_q <= 1'b0;
        end else begin
          scratch_slot_q <= pressed_next[kasq_pkg::SCRATCH_SLOT];
        end
      end
    end else begin : g_no_scratch
      assign scratch_slot_q = 1'b1;
    end
  endgenerate

  kasq_scratch u_scratch (
    .clk               (clk),
    .rst               (rst),
    .tick              (tick),
    .axis_value        (item.axis_value),
    .scratch_threshold (scratch_threshold),
    .frame_window      (frame_window),
    .wrap_half         (wrap_half),
    .slot_pressed      (scratch_slot_q),
    .scratch           (scratch)
  );

  // Row of slot cells with the press tally rippling from cell to cell.
  assign bump_chain[0] = '0;

  generate
    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      kasq_pkg::kasq_scratch_t cell_scratch;
      logic                    bind_sel;

      if (i == kasq_pkg::SCRATCH_SLOT) begin : g_scr
        assign cell_scratch = scratch;
      end else begin : g_key
        assign cell_scratch = '0;
      end

      assign bind_sel = (item.bind_slot == kasq_pkg::SLOT_BITS'(i));

      kasq_slot_cell #(
        .COUNT_BITS (COUNT_BITS),
        .CODE_BITS  (CODE_BITS),
        .BUMP_BITS  (BUMP_BITS)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .cmd          (cmd),
        .bind_sel     (bind_sel),
        .scratch      (cell_scratch),
        .bump_in      (bump_chain[i]),
        .bump_out     (bump_chain[i+1]),
        .pressed_next (pressed_next[i]),
        .count_next   (count_next[i])
      );
    end
  endgenerate

  // Result fields for the fixed number of output slots.
  generate
    for (genvar i = 0; i < OUTS; i++) begin : g_out
      if (i < NUM_SLOTS) begin : g_live
        logic [31:0] count_wide;
        assign count_wide        = 32'(count_next[i]);
        assign out_count_next[i] = count_wide[OCB-1:0];
        assign mask_next[i]      = pressed_next[i];
      end else begin : g_absent
        assign out_count_next[i] = '0;
        assign mask_next[i]      = 1'b0;
      end
    end
  endgenerate

  // The total follows the counts: it clears with them and adds each counted press.
  always_comb begin
    total_next = total;
    if (go && (cmd.action == kasq_pkg::ACT_CLEAR)) begin
      total_next = '0;
    end else begin
      total_next = total + kasq_pkg::TOTAL_BITS'(bump_chain[NUM_SLOTS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else begin
      total <= total_next;
    end
  end

  // Output register: loaded on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_mask  <= mask_next;
      out_fired <= scratch.fire;
      out_total <= total_next;
      for (int i = 0; i < OUTS; i++) begin
        out_count[i] <= out_count_next[i];
      end
    end
  end

  assign result.valid               = out_valid;
  assign result.pressed_mask        = out_mask;
  assign result.scratch_fired       = out_fired;
  assign result.total_count         = out_total;
  assign result.count_key_one       = out_count[0];
  assign result.count_key_two       = out_count[1];
  assign result.count_key_three     = out_count[2];
  assign result.count_key_four      = out_count[3];
  assign result.count_key_five      = out_count[4];
  assign result.count_key_six       = out_count[5];
  assign result.count_key_seven     = out_count[6];
  assign result.count_scratch_left  = out_count[7];
  assign result.count_scratch_right = out_count[8];

  // Checks on the qualifier's own logic.
  `ASSERT_SAME(a_fire_presses, clk, rst, result.valid && result.scratch_fired,
    result.pressed_mask[kasq_pkg::SCRATCH_SLOT])
  `ASSERT_SAME(a_fire_xor_release, clk, rst, 1'b1, !(scratch.fire && scratch.release_slot))
  `ASSERT_SAME(a_stall_blocks_input, clk, rst, out_valid && !result.ready, !item.ready)
  `ASSERT_NEXT(a_clear_total, clk, rst, go && (cmd.action == kasq_pkg::ACT_CLEAR),
    result.valid && (result.total_count == '0))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Key and scratch qualifier testbench
// Drives key, bind, clear and frame tick items into the qualifier core with
// bursty transfers and a stalling result receiver. A predictor of the slot
// table and the scratch accumulator runs on every input transfer, and each
// result transfer is checked field by field against the oldest prediction.
// The run steps through several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_KEYS         = 9;
  localparam int CNT_BITS         = 24;
  localparam int FIRE_SLOT        = kasq_pkg::SCRATCH_SLOT;
  localparam int FRAME_MAX        = 127;
  localparam int CODE_POOL        = 12;
  localparam int ITEMS_PER_PHASE  = 290;
  localparam int LONG_HOLD_AFTER  = 150;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 4;
  localparam int MAX_REPORTED     = 10;
  localparam int CYCLE_LIMIT      = 200000;

  // Action codes that the block leaves without effect
  localparam logic [kasq_pkg::ACTION_BITS-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [kasq_pkg::ACTION_BITS-1:0] ACT_SPARE_MID   = 3'd6;
  localparam logic [kasq_pkg::ACTION_BITS-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam logic [CNT_BITS-1:0]           CNT_MAX    = '1;
  localparam logic [kasq_pkg::SUM_BITS-1:0] MOTION_MAX = '1;

  // Receiver stall patterns
  typedef enum int {RX_FREE, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;

  typedef struct packed {
    logic [kasq_pkg::ACTION_BITS-1:0]      action;
    logic [kasq_pkg::KEY_BITS-1:0]         code;
    logic signed [kasq_pkg::AXIS_BITS-1:0] axis;
    logic [kasq_pkg::SLOT_BITS-1:0]        slot;
  } key_event_t;

  typedef struct packed {
    logic [kasq_pkg::MASK_BITS-1:0]                               mask;
    logic                                                         fired;
    logic [kasq_pkg::TOTAL_BITS-1:0]                              total;
    logic [kasq_pkg::OUT_SLOTS-1:0][kasq_pkg::OUT_COUNT_BITS-1:0] cnt;
  } slot_report_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [kasq_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [kasq_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  kasq_item_if   item_ch();
  kasq_result_if result_ch();

  key_and_scratch_qualifier_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Predictor copy of the register file
  logic [kasq_pkg::THRESH_BITS-1:0] thresh_cfg;
  logic [kasq_pkg::WINDOW_BITS-1:0] window_cfg;
  logic [kasq_pkg::HALF_BITS-1:0]   half_cfg;
  logic                             scratch_on;

  // Predictor copy of the slot table and scratch accumulator
  logic [kasq_pkg::KEY_BITS-1:0]         bind_code [NUM_KEYS];
  logic                                  held      [NUM_KEYS];
  logic [CNT_BITS-1:0]                   press_cnt [NUM_KEYS];
  logic [kasq_pkg::SUM_BITS-1:0]         motion_acc;
  int                                    frame_cnt;
  logic signed [kasq_pkg::AXIS_BITS-1:0] prev_axis;

  key_event_t   pending_events[$];
  slot_report_t expected_reports[$];

  key_event_t   next_ev;
  key_event_t   sent_ev;
  slot_report_t mon_want;
  slot_report_t mon_got;

  int gap_left;
  int burst_left;
  int hold_left;
  int mode_left;
  int phase_ctr;
  rx_mode_t stall_mode;
  bit long_hold_done;

  int items_sent;
  int results_seen;
  int fires_seen;
  int fault_count;
  int settings_applied;
  int cycle_count;

  logic [kasq_pkg::KEY_BITS-1:0]         code_pool [CODE_POOL];
  logic signed [kasq_pkg::AXIS_BITS-1:0] axis_cursor;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturating press counter of one slot.
  function automatic void bump_presses(int k);
    if (press_cnt[k] != CNT_MAX) press_cnt[k] = press_cnt[k] + 1'b1;
  endfunction

  // One frame tick of the scratch detector; returns 1 when the scratch slot fires.
  function automatic logic scratch_tick(logic signed [kasq_pkg::AXIS_BITS-1:0] axis);
    longint half;
    longint diff;
    longint acc;
    logic   hit;
    half = longint'(half_cfg);
    diff = longint'(axis) - longint'(prev_axis);
    hit  = 1'b0;
    // Fold the change back into one span of the axis.
    if (diff > half - 1) diff = diff - 2 * half;
    else if (diff < -half) diff = diff + 2 * half;
    if (diff < 0) diff = -diff;
    acc = longint'(motion_acc) + diff;
    motion_acc = (acc > longint'(MOTION_MAX)) ? MOTION_MAX : acc[kasq_pkg::SUM_BITS-1:0];
    if (frame_cnt < FRAME_MAX) frame_cnt++;
    if (motion_acc >= thresh_cfg && frame_cnt <= int'(window_cfg) && !held[FIRE_SLOT]) begin
      held[FIRE_SLOT] = 1'b1;
      bump_presses(FIRE_SLOT);
      hit        = 1'b1;
      motion_acc = '0;
      frame_cnt  = 0;
    end else if (frame_cnt > int'(window_cfg)) begin
      held[FIRE_SLOT] = 1'b0;
      motion_acc      = '0;
      frame_cnt       = 0;
    end
    prev_axis = axis;
    return hit;
  endfunction

  // Applies one item to the slot table and returns the result it produces.
  function automatic slot_report_t qualify_item(key_event_t ev);
    slot_report_t                    r;
    logic [kasq_pkg::TOTAL_BITS-1:0] total;
    r     = '0;
    total = '0;
    case (ev.action)
      kasq_pkg::ACT_KEY_DOWN: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (ev.code == bind_code[k] && !held[k]) begin
            held[k] = 1'b1;
            bump_presses(k);
          end
        end
      end
      kasq_pkg::ACT_KEY_UP: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (ev.code == bind_code[k]) held[k] = 1'b0;
        end
      end
      kasq_pkg::ACT_TICK: begin
        if (scratch_on) r.fired = scratch_tick(ev.axis);
      end
      kasq_pkg::ACT_BIND: begin
        if (ev.slot < NUM_KEYS) bind_code[ev.slot] = ev.code;
      end
      kasq_pkg::ACT_CLEAR: begin
        for (int k = 0; k < NUM_KEYS; k++) press_cnt[k] = '0;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < NUM_KEYS; k++) begin
      total     = total + press_cnt[k];
      r.mask[k] = held[k];
      r.cnt[k]  = press_cnt[k];
    end
    r.total = total;
    return r;
  endfunction

  // Compares one result field and reports the first few faults.
  task automatic check_field(string name, logic [kasq_pkg::TOTAL_BITS-1:0] want,
                             logic [kasq_pkg::TOTAL_BITS-1:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTED)
        $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
    end
  endtask

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_reg(kasq_pkg::kasq_cfg_t idx, logic [kasq_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      kasq_pkg::CFG_THRESHOLD: thresh_cfg = data[kasq_pkg::THRESH_BITS-1:0];
      kasq_pkg::CFG_WINDOW:    window_cfg = data[kasq_pkg::WINDOW_BITS-1:0];
      kasq_pkg::CFG_WRAP_HALF: half_cfg   = data[kasq_pkg::HALF_BITS-1:0];
      kasq_pkg::CFG_ENABLE:    scratch_on = data[0];
      default: begin
      end
    endcase
    settings_applied++;
  endtask

  // Waits until every queued item has been transferred and every result checked.
  // The test is made between rising edges, once the driver has settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || item_ch.valid || expected_reports.size() != 0);
  endtask

  task automatic add_item(logic [kasq_pkg::ACTION_BITS-1:0] act,
                          logic [kasq_pkg::KEY_BITS-1:0] code,
                          logic signed [kasq_pkg::AXIS_BITS-1:0] axis,
                          logic [kasq_pkg::SLOT_BITS-1:0] slot);
    key_event_t ev;
    ev.action = act;
    ev.code   = code;
    ev.axis   = axis;
    ev.slot   = slot;
    pending_events.push_back(ev);
  endtask

  // Mostly well-formed key and tick traffic on bound codes, with some noise.
  task automatic add_random_item();
    int                                    pick;
    int                                    sel;
    logic [kasq_pkg::KEY_BITS-1:0]         code;
    logic signed [kasq_pkg::AXIS_BITS-1:0] step;
    pick = $urandom_range(0, 99);
    code = code_pool[$urandom_range(0, CODE_POOL - 1)];
    if (pick < 35) begin
      add_item(kasq_pkg::ACT_KEY_DOWN, code, kasq_pkg::AXIS_BITS'($urandom),
               kasq_pkg::SLOT_BITS'($urandom));
    end else if (pick < 60) begin
      add_item(kasq_pkg::ACT_KEY_UP, code, kasq_pkg::AXIS_BITS'($urandom),
               kasq_pkg::SLOT_BITS'($urandom));
    end else if (pick < 85) begin
      // Turntable motion: fast spins, slow drift, jumps across the wrap, rest.
      sel = $urandom_range(0, 9);
      if (sel < 4) step = kasq_pkg::AXIS_BITS'($urandom_range(500, 4000));
      else if (sel < 7) step = kasq_pkg::AXIS_BITS'($urandom_range(0, 200));
      else if (sel < 9) step = kasq_pkg::AXIS_BITS'($urandom);
      else step = '0;
      if ($urandom_range(0, 1) != 0) step = -step;
      axis_cursor = axis_cursor + step;
      add_item(kasq_pkg::ACT_TICK, kasq_pkg::KEY_BITS'($urandom), axis_cursor,
               kasq_pkg::SLOT_BITS'($urandom));
    end else if (pick < 91) begin
      if ($urandom_range(0, 3) == 0) code = kasq_pkg::KEY_BITS'($urandom);
      add_item(kasq_pkg::ACT_BIND, code, kasq_pkg::AXIS_BITS'($urandom),
               kasq_pkg::SLOT_BITS'($urandom_range(0, NUM_KEYS - 1)));
    end else if (pick < 94) begin
      add_item(kasq_pkg::ACT_CLEAR, kasq_pkg::KEY_BITS'($urandom),
               kasq_pkg::AXIS_BITS'($urandom), kasq_pkg::SLOT_BITS'($urandom));
    end else begin
      add_item(kasq_pkg::ACTION_BITS'($urandom_range(0, 7)), kasq_pkg::KEY_BITS'($urandom),
               kasq_pkg::AXIS_BITS'($urandom), kasq_pkg::SLOT_BITS'($urandom));
    end
  endtask

  // One random phase: new register setting, fresh bindings, then random traffic.
  task automatic run_random_phase(logic [kasq_pkg::THRESH_BITS-1:0] thr,
                                  logic [kasq_pkg::WINDOW_BITS-1:0] win,
                                  logic [kasq_pkg::HALF_BITS-1:0] half, logic en);
    logic [kasq_pkg::CFG_DATA_BITS-1:0] junk;
    wait_idle();
    write_reg(kasq_pkg::CFG_THRESHOLD, thr);
    junk = kasq_pkg::CFG_DATA_BITS'($urandom);
    write_reg(kasq_pkg::CFG_WINDOW, (junk & 16'hFFC0) | kasq_pkg::CFG_DATA_BITS'(win));
    write_reg(kasq_pkg::CFG_WRAP_HALF, half);
    junk = kasq_pkg::CFG_DATA_BITS'($urandom);
    write_reg(kasq_pkg::CFG_ENABLE, (junk & 16'hFFFE) | kasq_pkg::CFG_DATA_BITS'(en));
    for (int k = 0; k < CODE_POOL; k++) code_pool[k] = kasq_pkg::KEY_BITS'($urandom);
    // Binding from the first part of the pool makes shared codes likely.
    for (int k = 0; k < NUM_KEYS; k++)
      add_item(kasq_pkg::ACT_BIND, code_pool[$urandom_range(0, 7)],
               kasq_pkg::AXIS_BITS'($urandom), kasq_pkg::SLOT_BITS'(k));
    for (int n = 0; n < ITEMS_PER_PHASE; n++) add_random_item();
  endtask

  // Item driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      gap_left      = 0;
      burst_left    = 1;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        sent_ev.action = item_ch.action;
        sent_ev.code   = item_ch.key_code;
        sent_ev.axis   = item_ch.axis_value;
        sent_ev.slot   = item_ch.bind_slot;
        expected_reports.push_back(qualify_item(sent_ev));
        items_sent++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          next_ev = pending_events.pop_front();
          item_ch.valid      <= 1'b1;
          item_ch.action     <= next_ev.action;
          item_ch.key_code   <= next_ev.code;
          item_ch.axis_value <= next_ev.axis;
          item_ch.bind_slot  <= next_ev.slot;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: changing stall patterns and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left  = 0;
      mode_left  = 0;
      phase_ctr  = 0;
      stall_mode = RX_FREE;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 64);
      end else begin
        mode_left--;
      end
      phase_ctr++;
      case (stall_mode)
        RX_FREE:    result_ch.ready <= 1'b1;
        RX_COIN:    result_ch.ready <= ($urandom_range(0, 1) != 0);
        RX_QUARTER: result_ch.ready <= (phase_ctr % 4 == 0);
        default:    result_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result monitor: every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTED)
          $display("Result %0d arrived with no prediction waiting", results_seen);
      end else begin
        mon_want = expected_reports.pop_front();
        mon_got.mask   = result_ch.pressed_mask;
        mon_got.fired  = result_ch.scratch_fired;
        mon_got.total  = result_ch.total_count;
        mon_got.cnt[0] = result_ch.count_key_one;
        mon_got.cnt[1] = result_ch.count_key_two;
        mon_got.cnt[2] = result_ch.count_key_three;
        mon_got.cnt[3] = result_ch.count_key_four;
        mon_got.cnt[4] = result_ch.count_key_five;
        mon_got.cnt[5] = result_ch.count_key_six;
        mon_got.cnt[6] = result_ch.count_key_seven;
        mon_got.cnt[7] = result_ch.count_scratch_left;
        mon_got.cnt[8] = result_ch.count_scratch_right;
        check_field("pressed mask", kasq_pkg::TOTAL_BITS'(mon_want.mask),
                    kasq_pkg::TOTAL_BITS'(mon_got.mask));
        check_field("scratch fired", kasq_pkg::TOTAL_BITS'(mon_want.fired),
                    kasq_pkg::TOTAL_BITS'(mon_got.fired));
        check_field("total count", mon_want.total, mon_got.total);
        for (int k = 0; k < kasq_pkg::OUT_SLOTS; k++)
          check_field($sformatf("count of slot %0d", k),
                      kasq_pkg::TOTAL_BITS'(mon_want.cnt[k]),
                      kasq_pkg::TOTAL_BITS'(mon_got.cnt[k]));
        if (mon_want.fired) fires_seen++;
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d predictions waiting",
             cycle_count, expected_reports.size());
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus sequence
  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = kasq_pkg::CFG_THRESHOLD;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.action       = kasq_pkg::ACT_KEY_DOWN;
    item_ch.key_code     = '0;
    item_ch.axis_value   = '0;
    item_ch.bind_slot    = '0;
    result_ch.ready      = 1'b0;
    long_hold_done       = 1'b0;
    items_sent           = 0;
    results_seen         = 0;
    fires_seen           = 0;
    fault_count          = 0;
    settings_applied     = 0;
    axis_cursor          = '0;
    thresh_cfg           = kasq_pkg::THRESH_RESET;
    window_cfg           = kasq_pkg::WINDOW_RESET;
    half_cfg             = kasq_pkg::HALF_RESET;
    scratch_on           = 1'b0;
    motion_acc           = '0;
    frame_cnt            = 0;
    prev_axis            = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      bind_code[k] = '0;
      held[k]      = 1'b0;
      press_cnt[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset bindings are all zero, so code zero presses every slot at once.
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'h00, 16'sh7FFF, 4'hF);
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'h00, -16'sd32768, 4'h0);
    add_item(kasq_pkg::ACT_KEY_UP, 8'h00, 16'sh0000, 4'h5);
    add_item(kasq_pkg::ACT_BIND, 8'hFF, 16'sh0000, 4'd0);
    add_item(kasq_pkg::ACT_BIND, 8'h80, 16'sh0000, 4'd8);
    add_item(kasq_pkg::ACT_BIND, 8'h5A, 16'sh0000, 4'd7);
    // Bind slots beyond the last one are ignored.
    add_item(kasq_pkg::ACT_BIND, 8'h33, 16'sh0000, 4'd15);
    add_item(kasq_pkg::ACT_BIND, 8'h11, 16'sh0000, 4'd9);
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'hFF, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'h33, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'h80, 16'sh0000, 4'h0);
    // With scratch detection off a tick changes nothing.
    add_item(kasq_pkg::ACT_TICK, 8'h00, 16'sh7FFF, 4'h0);
    add_item(ACT_SPARE_FIRST, 8'hA5, 16'sh1234, 4'h3);
    add_item(ACT_SPARE_MID, 8'hFF, -16'sd1, 4'hF);
    add_item(ACT_SPARE_LAST, 8'h00, 16'sh0000, 4'h8);
    add_item(kasq_pkg::ACT_KEY_UP, 8'hFF, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_CLEAR, 8'h00, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'h5A, 16'sh0000, 4'h0);

    // Scratch detection on the reset threshold, window and wrap span.
    wait_idle();
    write_reg(kasq_pkg::CFG_ENABLE, 16'h0001);
    add_item(kasq_pkg::ACT_KEY_UP, 8'h5A, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_TICK, 8'h00, 16'sh7FFF, 4'h0);
    add_item(kasq_pkg::ACT_TICK, 8'h00, -16'sd32768, 4'h0);
    for (int n = 0; n < 4; n++) add_item(kasq_pkg::ACT_TICK, 8'h00, -16'sd32768, 4'h0);
    add_item(kasq_pkg::ACT_TICK, 8'h00, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_KEY_DOWN, 8'h5A, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_KEY_UP, 8'h5A, 16'sh0000, 4'h0);
    add_item(kasq_pkg::ACT_TICK, 8'h00, 16'sh0001, 4'h0);

    // Random phases over a spread of settings, extremes included.
    run_random_phase(16'd3000, 6'd4, 16'd32768, 1'b1);
    run_random_phase(16'd0, 6'd0, 16'd1, 1'b1);
    run_random_phase(16'd65535, 6'd63, 16'd32768, 1'b1);
    run_random_phase(kasq_pkg::THRESH_BITS'($urandom_range(500, 8000)),
                     kasq_pkg::WINDOW_BITS'($urandom_range(1, 10)), 16'd0, 1'b1);
    run_random_phase(kasq_pkg::THRESH_BITS'($urandom), kasq_pkg::WINDOW_BITS'($urandom),
                     kasq_pkg::HALF_BITS'($urandom_range(1, 32768)), 1'b0);
    run_random_phase(kasq_pkg::THRESH_BITS'($urandom_range(0, 20000)),
                     kasq_pkg::WINDOW_BITS'($urandom_range(0, 63)),
                     kasq_pkg::HALF_BITS'($urandom_range(1, 32768)), 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      fault_count += expected_reports.size();
      $display("%0d predictions were never matched by a result", expected_reports.size());
    end
    $display("Checked %0d results for %0d items across %0d register writes.",
             results_seen, items_sent, settings_applied);
    $display("The scratch slot fired %0d times; %0d faults were found.",
             fires_seen, fault_count);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
